/* hw/rtl/i2da_pkg.sv */
// Package for integer_to_decimal_ascii: payload structs, character codes,
// divide-by-ten reciprocal and the back-end state type. No dependencies.
package i2da_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_DIGITS  = 10;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
    localparam logic [32:0] RECIP       = 33'h0CCCCCCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic        func;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [5:0] char_code;
        logic       last;
        logic [3:0] total_length;
    } t_out_item;

    // classified job passed from front to back
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_back_state;

endpackage

/* hw/rtl/integer_to_decimal_ascii.sv */
// Top level of integer_to_decimal_ascii: front classifier, job queue and
// digit back end. Depends on i2da_pkg, i2da_front, i2da_queue, i2da_back.
//
//  channel  | ports                  | transfer when
//  ---------+------------------------+-----------------------
//  input    | push, full, i_item     | push && !full
//  result   | empty, pop, o_result   | pop && !empty
//
// A number of n digits is taken from the queue, runs n steps of the
// divide-by-ten loop (one multiply by the reciprocal per digit), then
// leaves one character at a time, a minus sign first if negative.
// The job queue keeps taking inputs while the back end works; full rises
// only once it holds QUEUE_DEPTH jobs. A stalled pop holds the output
// register and pauses emission. Synchronous active-low reset empties all.
module integer_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = i2da_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  i2da_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output i2da_pkg::t_out_item o_result
);

    i2da_pkg::t_job front_job;
    i2da_pkg::t_job queue_job;
    logic           queue_valid;
    logic           job_take;
    logic           out_valid;

    i2da_front u_front (
        .i_item (i_item),
        .o_job  (front_job)
    );

    i2da_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (push),
        .i_wr_data  (front_job),
        .o_full     (full),
        .i_rd       (job_take),
        .o_rd_valid (queue_valid),
        .o_rd_data  (queue_job)
    );

    i2da_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_take  (job_take),
        .o_out_valid (out_valid),
        .o_out       (o_result),
        .i_out_take  (pop)
    );

    assign empty = !out_valid;

endmodule

/* hw/rtl/i2da_front.sv */
// Front end: classifies an input item into sign flag and magnitude.
// Depends on i2da_pkg.
module i2da_front (
    input  i2da_pkg::t_in_item i_item,
    output i2da_pkg::t_job     o_job
);

    logic negative;

    // magnitude taken as unsigned 32 bits, so the most negative value is exact
    assign negative    = i_item.func && i_item.value[31];
    assign o_job.neg   = negative;
    assign o_job.mag   = negative ? (32'd0 - i_item.value) : i_item.value;

endmodule

/* hw/rtl/i2da_queue.sv */
// Short job queue between the front and back ends.
// Depends on i2da_pkg.
module i2da_queue #(
    parameter int DEPTH = i2da_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  i2da_pkg::t_job i_wr_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_rd_valid,
    output i2da_pkg::t_job o_rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    i2da_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_wr, do_rd;

    assign o_full     = (r_count == FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rptr];
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && o_rd_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
        end
        if (do_rd) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

/* hw/rtl/i2da_back.sv */
// Back end: one divide-by-ten step per cycle collects digits, then the
// characters leave most significant first through an output register.
// Depends on i2da_pkg.
module i2da_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  i2da_pkg::t_job        i_job,
    output logic                  o_job_take,
    output logic                  o_out_valid,
    output i2da_pkg::t_out_item   o_out,
    input  logic                  i_out_take
);

    localparam int IW = i2da_pkg::DIG_IDX_W;

    i2da_pkg::t_back_state r_state, n_state;
    logic [31:0]           r_cur, n_cur;
    logic                  r_neg, n_neg;
    logic                  r_sign_pend, n_sign_pend;
    logic [IW-1:0]         r_ndig, n_ndig;
    logic [IW-1:0]         r_idx, n_idx;
    logic [3:0]            r_digits [i2da_pkg::MAX_DIGITS];
    i2da_pkg::t_out_item   r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [64:0]   prod;
    logic [31:0]   quot;
    logic [3:0]    q10_lo;
    logic [3:0]    digit;
    logic          dig_wr;
    logic          out_free;
    logic [IW-1:0] rd_idx;
    logic [3:0]    rd_digit;

    // remainder is below ten, so four low bits of x - 10q are enough
    assign prod     = {33'd0, r_cur} * {32'd0, i2da_pkg::RECIP};
    assign quot     = 32'(prod[64:i2da_pkg::RECIP_SHIFT]);
    assign q10_lo   = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    assign digit    = r_cur[3:0] - q10_lo;
    assign out_free = !r_out_valid || i_out_take;
    assign rd_idx   = r_idx - IW'(1);
    assign rd_digit = r_digits[rd_idx[$clog2(i2da_pkg::MAX_DIGITS)-1:0]];

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_neg       = r_neg;
        n_sign_pend = r_sign_pend;
        n_ndig      = r_ndig;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_take;
        o_job_take  = 1'b0;
        dig_wr      = 1'b0;
        unique case (r_state)
            i2da_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    n_cur      = i_job.mag;
                    n_neg      = i_job.neg;
                    n_ndig     = '0;
                    n_state    = i2da_pkg::ST_CONV;
                end
            end
            i2da_pkg::ST_CONV: begin
                dig_wr = 1'b1;
                n_cur  = quot;
                n_ndig = r_ndig + IW'(1);
                if (quot == '0) begin
                    n_idx       = r_ndig + IW'(1);
                    n_sign_pend = r_neg;
                    n_state     = i2da_pkg::ST_EMIT;
                end
            end
            i2da_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_sign_pend        = 1'b0;
                        n_out.char_code    = i2da_pkg::CHAR_MINUS;
                        n_out.last         = 1'b0;
                        n_out.total_length = '0;
                    end else begin
                        n_out.char_code = i2da_pkg::CHAR_ZERO + {2'b00, rd_digit};
                        n_out.last      = (r_idx == IW'(1));
                        n_out.total_length = '0;
                        n_idx           = rd_idx;
                        if (r_idx == IW'(1)) begin
                            n_out.total_length = 4'(r_ndig) + {3'b000, r_neg};
                            n_state            = i2da_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = i2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2da_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sign_pend <= n_sign_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_neg  <= n_neg;
        r_ndig <= n_ndig;
        r_idx  <= n_idx;
        r_out  <= n_out;
        if (dig_wr) begin
            r_digits[r_ndig[$clog2(i2da_pkg::MAX_DIGITS)-1:0]] <= digit;
        end
    end

endmodule
